FILE: sv/fxmll_pkg.sv
// shared constants, config register codes and the exp rom for the mixture
// log likelihood block; no dependencies
package fxmll_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LL_W       = 48;
  localparam int CNT_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [32:0] LN2_Q32         = 33'd2977044472;
  localparam logic [32:0] LOG2E_Q32       = 33'd6196328019;
  localparam logic [15:0] HALF_LN_2PI_Q16 = 16'd60224;
  localparam logic [21:0] EXP_FLOOR_Q16   = 22'd2621440;

  localparam logic signed [LL_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [LL_W-1:0] ACC_MIN = 48'sh8000_0000_0000;
  localparam logic [CNT_W-1:0]       COUNT_MAX = 24'hFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN_PE    = 3'd0,
    CFG_GAIN       = 3'd1,
    CFG_EXCESS_VAR = 3'd2,
    CFG_PED_VAR    = 3'd3,
    CFG_PED_OFFSET = 3'd4
  } cfg_idx_t;

  typedef logic [31:0] exp_rom_t [16];

  // integer square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // entry i holds 2^-(2^(i-16)) in q.32
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t rom;
    rom[15] = 32'(isqrt64(64'h8000_0000_0000_0000));
    for (int i = 15; i >= 1; i--) begin
      rom[i-1] = 32'(isqrt64({rom[i], 32'b0}));
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  function automatic logic signed [LL_W-1:0] sat48(input logic signed [49:0] v);
    if (v > 50'(ACC_MAX)) begin
      return ACC_MAX;
    end else if (v < 50'(ACC_MIN)) begin
      return ACC_MIN;
    end
    return v[LL_W-1:0];
  endfunction

endpackage

FILE: sv/fixed_term_mixture_log_likelihood_top.sv
// top level of the poisson-gaussian mixture log likelihood block
// depends on fxmll_pkg, fxmll_log, fxmll_exp, fxmll_div
//
// usage
//   cfg_*: register writes (index, data), taken while the block is idle;
//   a write to a defined index forces a table rebuild on the next sample.
//   in_*: one charge sample per beat, in_last closes the batch.
//   out_*: one beat per batch with the log likelihood, the sample count
//   and the underflow flag.
// sequencing
//   a table build, needed after reset or a write, runs one row per term,
//   paced by the divider and the log unit on each table row.
//   per sample: every term is passed through the single exp unit as the
//   term memory is walked, with a shorter path when the exponent is below
//   the exp floor, then a closing log; one sample is in work at a time.
// reset clears batch state and marks the tables stale; config registers
// return to their defaults. a finished result waits in the output register
// while out_stall is high; the next batch runs on and only its own result
// waits for that register to drain.
module fixed_term_mixture_log_likelihood_top #(
  parameter int NUM_TERMS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [fxmll_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                                    in_last,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [fxmll_pkg::LL_W-1:0]       out_log_likelihood,
  output logic [fxmll_pkg::CNT_W-1:0]             out_sample_count,
  output logic                                    out_underflow,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [fxmll_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fxmll_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import fxmll_pkg::*;

  localparam int TW = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;
  localparam logic [TW-1:0] LAST_TERM = TW'(NUM_TERMS - 1);

  typedef enum logic [20:0] {
    S_IDLE   = 21'd1 << 0,
    S_GSQ    = 21'd1 << 1,
    S_B2G2   = 21'd1 << 2,
    S_LNFA   = 21'd1 << 3,
    S_LNN    = 21'd1 << 4,
    S_LNN_W  = 21'd1 << 5,
    S_VAR    = 21'd1 << 6,
    S_VAR_W  = 21'd1 << 7,
    S_WR     = 21'd1 << 8,
    S_RD     = 21'd1 << 9,
    S_D      = 21'd1 << 10,
    S_SQ     = 21'd1 << 11,
    S_QH     = 21'd1 << 12,
    S_QL     = 21'd1 << 13,
    S_Y      = 21'd1 << 14,
    S_Y_W    = 21'd1 << 15,
    S_LNS    = 21'd1 << 16,
    S_LNS_W  = 21'd1 << 17,
    S_ACC    = 21'd1 << 18,
    S_MUL    = 21'd1 << 19,
    S_OUT    = 21'd1 << 20
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [23:0]        mean_pe_r;
  logic [19:0]        gain_r;
  logic [15:0]        excess_var_r;
  logic [23:0]        ped_var_r;
  logic signed [23:0] ped_offset_r;
  logic               tables_ready_r;

  // table build
  logic [39:0]        gsq_r;
  logic [39:0]        b2g2_r;
  logic [46:0]        var_r;
  logic signed [31:0] lnfa_r;
  logic signed [31:0] nlnfa_r;
  logic signed [31:0] lf_r;
  logic [31:0]        cen_r;
  logic [TW-1:0]      n_r;

  // per sample
  logic               last_r;
  logic signed [25:0] xq_r;
  logic [63:0]        sum_r;
  logic signed [31:0] w_r;
  logic [31:0]        hh_r;
  logic [26:0]        ad_r;
  logic [53:0]        d2_r;
  logic [53:0]        qh_r;
  logic [31:0]        ql_r;

  // batch
  logic signed [47:0] acc_r;
  logic [23:0]        count_r;
  logic               zero_seen_r;
  logic [39:0]        prod_r;

  logic               out_valid_r;
  logic signed [47:0] out_ll_r;
  logic [23:0]        out_cnt_r;
  logic               out_uf_r;

  // term memory: {log weight, half inverse variance, centre}
  logic [95:0] mem [NUM_TERMS];
  logic [95:0] rd_r;
  logic        mem_we;
  logic        mem_re;
  logic [95:0] mem_wd;

  // units
  logic               log_start, log_busy;
  logic [63:0]        log_v;
  logic [5:0]         log_frac;
  logic signed [31:0] log_res;
  logic               exp_start, exp_busy;
  logic signed [63:0] exp_y;
  logic [63:0]        exp_res;
  logic               div_start, div_busy;
  logic [47:0]        div_num;
  logic [46:0]        div_den;
  logic [31:0]        div_quo;

  logic               idle;
  logic               in_acc;
  logic               cfg_acc;
  logic               out_load;
  logic               n_ge2;
  logic               n_last;
  logic [46:0]        var_fix;
  logic signed [39:0] w_full;
  logic signed [31:0] w_sat;
  logic signed [33:0] d_s;
  logic [33:0]        ad_full;
  logic [63:0]        lo_prod;
  logic [54:0]        qsum;
  logic signed [25:0] xq_in;
  logic signed [47:0] res_val;

  fxmll_log u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start),
    .v      (log_v),
    .frac   (log_frac),
    .busy   (log_busy),
    .result (log_res)
  );

  fxmll_exp u_exp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (exp_start),
    .y      (exp_y),
    .busy   (exp_busy),
    .result (exp_res)
  );

  fxmll_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  always_comb begin
    idle      = (state_r == S_IDLE);
    cfg_ready = idle;
    in_stall  = !idle || cfg_valid;
    cfg_acc   = cfg_valid && cfg_ready;
    in_acc    = in_valid && !in_stall;
    out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
    n_ge2     = (7'(n_r) >= 7'd2);
    n_last    = (n_r == LAST_TERM);
    var_fix   = (var_r == 47'd0) ? 47'd1 : var_r;
    div_num   = 48'h8000_0000_0000 + 48'(var_fix >> 1);
    div_den   = var_fix;

    w_full = 40'(nlnfa_r) - $signed({16'b0, mean_pe_r}) - 40'(lf_r) - 40'(log_res >>> 1);
    if (w_full > 40'sd2147483647) begin
      w_sat = 32'sh7FFF_FFFF;
    end else if (w_full < -40'sd2147483648) begin
      w_sat = 32'sh8000_0000;
    end else begin
      w_sat = w_full[31:0];
    end
    mem_wd = {w_sat, div_quo, cen_r};
    mem_we = (state_r == S_WR);
    mem_re = (state_r == S_RD);

    xq_in = $signed({{2{in_sample[15]}}, in_sample, 8'b0})
          - $signed({{2{ped_offset_r[23]}}, ped_offset_r});
    d_s     = 34'(xq_r) - $signed({2'b0, rd_r[31:0]});
    ad_full = (d_s < 34'sd0) ? 34'(-d_s) : 34'(d_s);
    lo_prod = 64'(d2_r[31:0]) * 64'(hh_r);
    qsum    = 55'(qh_r) + 55'(ql_r);
    exp_y   = 64'(w_r) - $signed({9'b0, qsum});
    res_val = sat48(50'(acc_r) - $signed({10'b0, prod_r}));

    log_start = 1'b0;
    log_v     = 64'(mean_pe_r);
    log_frac  = 6'd16;
    case (state_r)
      S_B2G2: begin
        log_start = 1'b1;
      end
      S_LNN: begin
        log_start = n_ge2;
        log_v     = 64'(n_r);
        log_frac  = 6'd0;
      end
      S_VAR: begin
        log_start = 1'b1;
        log_v     = 64'(var_fix);
      end
      S_LNS: begin
        log_start = (sum_r != 64'd0);
        log_v     = sum_r;
        log_frac  = 6'd56;
      end
      default: ;
    endcase
    div_start = (state_r == S_VAR);
    exp_start = (state_r == S_Y);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = tables_ready_r ? S_RD : S_GSQ;
      S_GSQ:   state_nxt = S_B2G2;
      S_B2G2:  state_nxt = S_LNFA;
      S_LNFA:  if (!log_busy) state_nxt = S_LNN;
      S_LNN:   state_nxt = n_ge2 ? S_LNN_W : S_VAR;
      S_LNN_W: if (!log_busy) state_nxt = S_VAR;
      S_VAR:   state_nxt = S_VAR_W;
      S_VAR_W: if (!log_busy && !div_busy) state_nxt = S_WR;
      S_WR:    state_nxt = n_last ? S_RD : S_LNN;
      S_RD:    state_nxt = S_D;
      S_D:     state_nxt = S_SQ;
      S_SQ:    state_nxt = S_QH;
      S_QH:    state_nxt = S_QL;
      S_QL:    state_nxt = S_Y;
      S_Y:     state_nxt = S_Y_W;
      S_Y_W:   if (!exp_busy) state_nxt = n_last ? S_LNS : S_RD;
      S_LNS:   state_nxt = (sum_r != 64'd0) ? S_LNS_W : S_ACC;
      S_LNS_W: if (!log_busy) state_nxt = S_ACC;
      S_ACC:   state_nxt = last_r ? S_MUL : S_IDLE;
      S_MUL:   state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[n_r] <= mem_wd;
    end
    if (mem_re) begin
      rd_r <= mem[n_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      mean_pe_r      <= 24'd65536;
      gain_r         <= 20'd25600;
      excess_var_r   <= 16'd16384;
      ped_var_r      <= 24'd25600;
      ped_offset_r   <= 24'sd0;
      tables_ready_r <= 1'b0;
      acc_r          <= '0;
      count_r        <= '0;
      zero_seen_r    <= 1'b0;
      n_r            <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        case (cfg_index)
          CFG_MEAN_PE: begin
            mean_pe_r      <= cfg_data;
            tables_ready_r <= 1'b0;
          end
          CFG_GAIN: begin
            gain_r         <= cfg_data[19:0];
            tables_ready_r <= 1'b0;
          end
          CFG_EXCESS_VAR: begin
            excess_var_r   <= cfg_data[15:0];
            tables_ready_r <= 1'b0;
          end
          CFG_PED_VAR: begin
            ped_var_r      <= cfg_data;
            tables_ready_r <= 1'b0;
          end
          CFG_PED_OFFSET: begin
            ped_offset_r   <= cfg_data;
            tables_ready_r <= 1'b0;
          end
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            last_r <= in_last;
            xq_r   <= xq_in;
            sum_r  <= '0;
            n_r    <= '0;
          end
        end
        S_GSQ: begin
          gsq_r <= 40'(gain_r) * 40'(gain_r);
        end
        S_B2G2: begin
          b2g2_r <= 40'((56'(excess_var_r) * 56'(gsq_r)) >> 16);
        end
        S_LNFA: begin
          if (!log_busy) begin
            lnfa_r  <= log_res;
            nlnfa_r <= '0;
            lf_r    <= '0;
            cen_r   <= '0;
            var_r   <= 47'({ped_var_r, 8'b0});
            n_r     <= '0;
          end
        end
        S_LNN_W: begin
          if (!log_busy) begin
            lf_r <= lf_r + log_res;
          end
        end
        S_WR: begin
          if (n_last) begin
            tables_ready_r <= 1'b1;
            n_r            <= '0;
          end else begin
            n_r     <= n_r + TW'(1);
            nlnfa_r <= nlnfa_r + lnfa_r;
            var_r   <= var_r + 47'(b2g2_r);
            cen_r   <= cen_r + 32'(gain_r);
          end
        end
        S_D: begin
          w_r  <= rd_r[95:64];
          hh_r <= rd_r[63:32];
          // distance stays below 2^27 over all field ranges
          ad_r <= ad_full[26:0];
        end
        S_SQ: begin
          d2_r <= 54'(ad_r) * 54'(ad_r);
        end
        S_QH: begin
          qh_r <= 54'(d2_r[53:32]) * 54'(hh_r);
        end
        S_QL: begin
          ql_r <= lo_prod[63:32];
        end
        S_Y_W: begin
          if (!exp_busy) begin
            sum_r <= sum_r + exp_res;
            if (!n_last) begin
              n_r <= n_r + TW'(1);
            end
          end
        end
        S_LNS: begin
          if (sum_r == 64'd0) begin
            zero_seen_r <= 1'b1;
          end
        end
        S_LNS_W: begin
          if (!log_busy) begin
            acc_r <= sat48(50'(acc_r) + 50'(log_res));
          end
        end
        S_ACC: begin
          if (count_r != COUNT_MAX) begin
            count_r <= count_r + 24'd1;
          end
        end
        S_MUL: begin
          prod_r <= 40'(count_r) * 40'(HALF_LN_2PI_Q16);
        end
        S_OUT: begin
          if (out_load) begin
            acc_r       <= '0;
            count_r     <= '0;
            zero_seen_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ll_r  <= zero_seen_r ? ACC_MIN : res_val;
      out_cnt_r <= count_r;
      out_uf_r  <= zero_seen_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_log_likelihood = out_ll_r;
  assign out_sample_count   = out_cnt_r;
  assign out_underflow      = out_uf_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_tables_before_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> tables_ready_r)
    else $error("term memory read before tables were built");

  a_log_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    log_start |-> !log_busy)
    else $error("log unit started while busy");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("pending result overwritten");

endmodule

FILE: sv/fxmll_log.sv
// iterative natural log unit, result q.16 of v / 2^frac
// normalize, 16 squaring steps for log2 fraction bits, scale by ln 2
// uses fxmll_pkg
module fxmll_log (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        v,
  input  logic [5:0]         frac,
  output logic               busy,
  output logic signed [31:0] result
);
  import fxmll_pkg::*;

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_NORM = 5'b00010,
    L_SQ   = 5'b00100,
    L_MUL  = 5'b01000,
    L_OUT  = 5'b10000
  } log_state_t;

  log_state_t st_r;
  logic [63:0] x_r;
  logic [5:0]  sh_r;
  logic [5:0]  frac_r;
  logic [31:0] m_r;
  logic [15:0] fb_r;
  logic [3:0]  it_r;
  logic signed [56:0] prod_r;
  logic signed [31:0] res_r;

  logic [63:0] sq;
  logic [32:0] t;
  logic signed [7:0]  e_s;
  logic signed [23:0] l2;
  logic signed [56:0] rnd;

  always_comb begin
    sq  = 64'(m_r) * 64'(m_r);
    t   = sq[63:31];
    e_s = 8'sd63 - $signed({2'b0, sh_r}) - $signed({2'b0, frac_r});
    l2  = {e_s, fb_r};
    rnd = (prod_r + 57'sd2147483648) >>> 32;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
    end else begin
      case (st_r)
        L_IDLE: begin
          if (start) begin
            x_r    <= (v == 64'd0) ? 64'd1 : v;
            sh_r   <= '0;
            frac_r <= frac;
            st_r   <= L_NORM;
          end
        end
        L_NORM: begin
          if (x_r[63]) begin
            m_r  <= x_r[63:32];
            fb_r <= '0;
            it_r <= '0;
            st_r <= L_SQ;
          end else if (x_r[63:48] == 16'd0) begin
            x_r  <= x_r << 16;
            sh_r <= sh_r + 6'd16;
          end else if (x_r[63:56] == 8'd0) begin
            x_r  <= x_r << 8;
            sh_r <= sh_r + 6'd8;
          end else begin
            x_r  <= x_r << 1;
            sh_r <= sh_r + 6'd1;
          end
        end
        L_SQ: begin
          fb_r <= {fb_r[14:0], t[32]};
          m_r  <= t[32] ? t[32:1] : t[31:0];
          it_r <= it_r + 4'd1;
          if (it_r == 4'd15) begin
            st_r <= L_MUL;
          end
        end
        L_MUL: begin
          prod_r <= 57'(l2) * $signed({24'b0, LN2_Q32});
          st_r   <= L_OUT;
        end
        L_OUT: begin
          res_r <= rnd[31:0];
          st_r  <= L_IDLE;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  assign busy   = (st_r != L_IDLE);
  assign result = res_r;

endmodule

FILE: sv/fxmll_exp.sv
// iterative exp unit: q.16 input clamped to <= 0, unsigned q.56 output
// one rom product per fraction bit of the base-2 exponent
// uses fxmll_pkg
module fxmll_exp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] y,
  output logic               busy,
  output logic [63:0]        result
);
  import fxmll_pkg::*;

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_MUL  = 4'b0010,
    E_ITER = 4'b0100,
    E_OUT  = 4'b1000
  } exp_state_t;

  exp_state_t st_r;
  logic [21:0] t_r;
  logic [5:0]  k_r;
  logic [15:0] f_r;
  logic [32:0] mant_r;
  logic [3:0]  it_r;
  logic [63:0] res_r;

  logic [63:0] t_full;
  logic [54:0] uu;
  logic [64:0] ep;
  logic [63:0] shl;

  always_comb begin
    t_full = (y > 64'sd0) ? 64'd0 : 64'(-y);
    uu     = 55'(t_r) * 55'(LOG2E_Q32) + 55'h8000_0000;
    ep     = 65'(mant_r) * 65'(EXP_ROM[it_r]);
    shl    = 64'(mant_r) << 24;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= E_IDLE;
    end else begin
      case (st_r)
        E_IDLE: begin
          if (start) begin
            if (t_full > 64'(EXP_FLOOR_Q16)) begin
              res_r <= '0;
            end else begin
              t_r  <= t_full[21:0];
              st_r <= E_MUL;
            end
          end
        end
        E_MUL: begin
          // integer part stays below 64 over the clamped range
          k_r    <= uu[53:48];
          f_r    <= uu[47:32];
          mant_r <= 33'h1_0000_0000;
          it_r   <= '0;
          st_r   <= E_ITER;
        end
        E_ITER: begin
          if (f_r[it_r]) begin
            mant_r <= ep[64:32];
          end
          it_r <= it_r + 4'd1;
          if (it_r == 4'd15) begin
            st_r <= E_OUT;
          end
        end
        E_OUT: begin
          res_r <= shl >> k_r;
          st_r  <= E_IDLE;
        end
        default: st_r <= E_IDLE;
      endcase
    end
  end

  assign busy   = (st_r != E_IDLE);
  assign result = res_r;

endmodule

FILE: sv/fxmll_div.sv
// restoring divider for the half inverse variance, one quotient bit a cycle
// quotient saturates to 32 bits; no package dependencies beyond fxmll_pkg
module fxmll_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [46:0] den,
  output logic        busy,
  output logic [31:0] quo
);
  import fxmll_pkg::*;

  typedef enum logic [1:0] {
    D_IDLE = 2'b01,
    D_RUN  = 2'b10
  } div_state_t;

  div_state_t st_r;
  logic [47:0] num_r;
  logic [46:0] den_r;
  logic [47:0] rem_r;
  logic [47:0] q_r;
  logic [5:0]  cnt_r;

  logic [48:0] r2;
  logic        ge;

  always_comb begin
    r2 = {rem_r, num_r[47]};
    ge = (r2 >= 49'(den_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= D_IDLE;
    end else begin
      case (st_r)
        D_IDLE: begin
          if (start) begin
            num_r <= num;
            den_r <= den;
            rem_r <= '0;
            q_r   <= '0;
            cnt_r <= '0;
            st_r  <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= ge ? 48'(r2 - 49'(den_r)) : r2[47:0];
          q_r   <= {q_r[46:0], ge};
          num_r <= num_r << 1;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd47) begin
            st_r <= D_IDLE;
          end
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign busy = (st_r != D_IDLE);
  assign quo  = (q_r[47:32] != 16'd0) ? 32'hFFFF_FFFF : q_r[31:0];

endmodule
